@@ rtl/assert_macros.svh @@
// Assertion macros included by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define CHK_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression never becomes true out of reset.
`define CHK_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/gdow_pkg.sv @@
// Package with the calendar constants, status codes and helper functions.
package gdow_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  localparam int unsigned LAST_DAY = 3652058;  // day number of 9999-12-31
  localparam int unsigned MAX_YEAR = 9999;
  localparam int unsigned YEAR_RECIP = 734951;  // floor(2^28 / 365.2425)
  localparam int unsigned YEAR_SHIFT = 28;

  localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
                                            5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [8:0] CUM_START [13] = '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120,
                                            9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
                                            9'd304, 9'd334};

  // Quotient by 100 through a reciprocal, exact for any 14-bit value.
  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [26:0] t;
    t = 27'(y) * 27'd5243;
    return t[26:19];
  endfunction

  // Leap test given the year and its quotient by 100.
  function automatic logic leap_yr(input logic [13:0] y, input logic [7:0] q);
    logic [13:0] hund;
    hund = 14'(q) * 14'd100;
    if (y == hund) return (q[1:0] == 2'd0);
    return (y[1:0] == 2'd0);
  endfunction

  // Remainder by 7: octal digits fold because 8 leaves 1.
  function automatic logic [2:0] mod7(input logic [21:0] x);
    logic [23:0] w;
    logic [5:0]  s;
    logic [3:0]  s2;
    w = {2'b00, x};
    s = '0;
    for (int i = 0; i < 8; i++) s = s + 6'(w[3*i +: 3]);
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    if (s2 >= 4'd14) return 3'd0;
    if (s2 >= 4'd7) return 3'(s2 - 4'd7);
    return s2[2:0];
  endfunction

endpackage

@@ rtl/gregorian_date_offset_weekday.sv @@
// Top level: Gregorian date plus signed day offset, with weekday, as a ten-stage pipeline.
//
//  channel | signals                                         | direction
//  in      | in_valid, in_stall, in_start_*, in_day_offset   | into block
//  out     | out_valid, out_stall, out_result_*, out_weekday | out of block
//
// One word may enter every cycle while no output stall holds the pipeline; the depth
// is set by the three reciprocal multiplies and the year correction. Reset clears only
// the stage valid bits. An output stall while out_valid is high freezes every stage at
// once and is passed back as in_stall.
`include "assert_macros.svh"

module gregorian_date_offset_weekday
  import gdow_pkg::*;
#(
  parameter int OFFSET_WIDTH = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [13:0]                    in_start_year,
  input  logic [3:0]                     in_start_month,
  input  logic [4:0]                     in_start_day,
  input  logic signed [OFFSET_WIDTH-1:0] in_day_offset,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [13:0]                    out_result_year,
  output logic [3:0]                     out_result_month,
  output logic [4:0]                     out_result_day,
  output logic [2:0]                     out_weekday,
  output logic [1:0]                     out_status
);

  localparam int NW = ((OFFSET_WIDTH > 22) ? OFFSET_WIDTH : 22) + 2;

  logic adv;
  logic [9:0] v_r;

  // Stage 1
  logic [13:0] y1_r;
  logic [3:0]  m1_r;
  logic [4:0]  d1_r;
  logic signed [OFFSET_WIDTH-1:0] o1_r;
  logic [7:0]  q1_r;
  // Stage 2
  logic        bad2_r;
  logic [13:0] p2_r;
  logic [7:0]  p100_2_r;
  logic [5:0]  p400_2_r;
  logic signed [NW-1:0] dof2_r;
  // Stage 3
  logic        bad3_r;
  logic [21:0] base3_r;
  logic signed [NW-1:0] dof3_r;
  // Stage 4
  status_t     st4_r;
  logic [21:0] n4_r;
  // Stage 5
  status_t     st5_r;
  logic [21:0] n5_r;
  logic [13:0] e5_r;
  logic [2:0]  wk5_r;
  // Stage 6
  status_t     st6_r;
  logic [21:0] n6_r;
  logic [13:0] e6_r;
  logic [7:0]  q6_r;
  logic [2:0]  wk6_r;
  // Stage 7
  status_t     st7_r;
  logic [21:0] n7_r;
  logic [13:0] e7_r;
  logic [22:0] db7_r;
  logic        lpe7_r, lpe17_r;
  logic [2:0]  wk7_r;
  // Stage 8
  status_t     st8_r;
  logic [13:0] yr8_r;
  logic [8:0]  r8_r;
  logic        lp8_r;
  logic [2:0]  wk8_r;
  // Stage 9
  status_t     st9_r;
  logic [13:0] yr9_r;
  logic [8:0]  r9_r;
  logic        lp9_r;
  logic [3:0]  rm9_r;
  logic [2:0]  wk9_r;
  // Output
  logic [13:0] oy_r;
  logic [3:0]  om_r;
  logic [4:0]  od_r;
  logic [2:0]  ow_r;
  status_t     ost_r;

  // Next values
  logic [7:0]  q1_nxt;
  logic        lp2, bad2_nxt;
  logic [3:0]  mi2;
  logic [4:0]  mlen2;
  logic [8:0]  doy2;
  logic        rz2;
  logic [13:0] hund2;
  logic signed [NW-1:0] dof2_nxt;
  logic [22:0] base3_nxt;
  logic signed [NW-1:0] nsum4;
  status_t     st4_nxt;
  logic [42:0] prod5;
  logic [7:0]  q6_nxt;
  logic [13:0] hund7;
  logic [6:0]  re7;
  logic [6:0]  re17;
  logic [7:0]  q17;
  logic [13:0] e17;
  logic        lpe7_nxt, lpe17_nxt;
  logic [22:0] db7_nxt;
  logic [13:0] yr8_nxt;
  logic [22:0] r8_full;
  logic        lp8_nxt;
  logic [3:0]  rm9_nxt;
  logic [8:0]  mstart10;
  logic [8:0]  day10;

  // Output word shape, for the checks at the end.
  logic out_ok;
  logic out_date_sane;
  logic out_fields_zero;

  assign adv       = !(v_r[9] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = v_r[9];

  always_comb begin
    q1_nxt = div100(in_start_year);

    // Stage 2: check the start date and find its day of year.
    lp2   = leap_yr(y1_r, q1_r);
    mi2   = (m1_r >= 4'd1 && m1_r <= 4'd12) ? m1_r : 4'd0;
    mlen2 = MONTH_LEN[mi2] + 5'((mi2 == 4'd2) && lp2);
    bad2_nxt = (y1_r == 14'd0) || (y1_r > 14'(MAX_YEAR)) || (mi2 == 4'd0) ||
               (d1_r == 5'd0) || (d1_r > mlen2);
    doy2  = CUM_START[mi2] + 9'(lp2 && (mi2 > 4'd2)) + 9'(d1_r) - 9'd1;
    hund2 = 14'(q1_r) * 14'd100;
    rz2   = (y1_r == hund2);
    dof2_nxt = $signed({{(NW-9){1'b0}}, doy2}) +
               $signed({{(NW-OFFSET_WIDTH){o1_r[OFFSET_WIDTH-1]}}, o1_r});

    // Stage 3: days before the start year.
    base3_nxt = 23'(p2_r) * 23'd365 + 23'(p2_r[13:2]) - 23'(p100_2_r) + 23'(p400_2_r);

    // Stage 4: day number and range check.
    nsum4 = $signed({{(NW-22){1'b0}}, base3_r}) + dof3_r;
    if (bad3_r) begin
      st4_nxt = ST_BAD_START;
    end else if (nsum4[NW-1] || (nsum4 > $signed(NW'(LAST_DAY)))) begin
      st4_nxt = ST_RANGE;
    end else begin
      st4_nxt = ST_OK;
    end

    // Stage 5: year estimate, true year or one below it.
    prod5 = 43'(n4_r + 22'd5) * 43'(YEAR_RECIP);

    // Stage 6
    q6_nxt = div100(e5_r);

    // Stage 7: days before the estimate and leap flags of years e and e+1.
    hund7 = 14'(q6_r) * 14'd100;
    re7   = 7'(e6_r - hund7);
    re17  = (re7 == 7'd99) ? 7'd0 : re7 + 7'd1;
    q17   = (re7 == 7'd99) ? q6_r + 8'd1 : q6_r;
    e17   = e6_r + 14'd1;
    lpe7_nxt  = (re7 == 7'd0) ? (q6_r[1:0] == 2'd0) : (e6_r[1:0] == 2'd0);
    lpe17_nxt = (re17 == 7'd0) ? (q17[1:0] == 2'd0) : (e17[1:0] == 2'd0);
    db7_nxt = 23'(e6_r) * 23'd365 + 23'(e6_r[13:2]) - 23'(q6_r) + 23'(q6_r[7:2]);

    // Stage 8: correct the estimate and take the day of year.
    if (db7_r > 23'(n7_r)) begin
      yr8_nxt = e7_r;
      r8_full = 23'(n7_r) + 23'd365 + 23'(lpe7_r) - db7_r;
      lp8_nxt = lpe7_r;
    end else begin
      yr8_nxt = e7_r + 14'd1;
      r8_full = 23'(n7_r) - db7_r;
      lp8_nxt = lpe17_r;
    end

    // Stage 9: month by parallel compares against month starts.
    rm9_nxt = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (r8_r >= CUM_START[k] + 9'(lp8_r && (k > 2))) rm9_nxt = rm9_nxt + 4'd1;
    end

    // Stage 10: day of month.
    mstart10 = CUM_START[rm9_r] + 9'(lp9_r && (rm9_r > 4'd2));
    day10    = r9_r - mstart10 + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_r <= in_start_year;
      m1_r <= in_start_month;
      d1_r <= in_start_day;
      o1_r <= in_day_offset;
      q1_r <= q1_nxt;

      bad2_r   <= bad2_nxt;
      p2_r     <= y1_r - 14'd1;
      p100_2_r <= q1_r - 8'(rz2);
      p400_2_r <= q1_r[7:2] - 6'(rz2 && (q1_r[1:0] == 2'd0));
      dof2_r   <= dof2_nxt;

      bad3_r  <= bad2_r;
      base3_r <= base3_nxt[21:0];
      dof3_r  <= dof2_r;

      st4_r <= st4_nxt;
      n4_r  <= nsum4[21:0];

      st5_r <= st4_r;
      n5_r  <= n4_r;
      e5_r  <= prod5[YEAR_SHIFT +: 14];
      wk5_r <= mod7(n4_r + 22'd1);

      st6_r <= st5_r;
      n6_r  <= n5_r;
      e6_r  <= e5_r;
      q6_r  <= q6_nxt;
      wk6_r <= wk5_r;

      st7_r   <= st6_r;
      n7_r    <= n6_r;
      e7_r    <= e6_r;
      db7_r   <= db7_nxt;
      lpe7_r  <= lpe7_nxt;
      lpe17_r <= lpe17_nxt;
      wk7_r   <= wk6_r;

      st8_r <= st7_r;
      yr8_r <= yr8_nxt;
      r8_r  <= r8_full[8:0];
      lp8_r <= lp8_nxt;
      wk8_r <= wk7_r;

      st9_r  <= st8_r;
      yr9_r  <= yr8_r;
      r9_r   <= r8_r;
      lp9_r  <= lp8_r;
      rm9_r  <= rm9_nxt;
      wk9_r  <= wk8_r;

      ost_r <= st9_r;
      if (st9_r == ST_OK) begin
        oy_r <= yr9_r;
        om_r <= rm9_r;
        od_r <= day10[4:0];
        ow_r <= wk9_r;
      end else begin
        oy_r <= '0;
        om_r <= '0;
        od_r <= '0;
        ow_r <= '0;
      end
    end
  end

  assign out_result_year  = oy_r;
  assign out_result_month = om_r;
  assign out_result_day   = od_r;
  assign out_weekday      = ow_r;
  assign out_status       = ost_r;

  assign out_ok          = out_valid && (out_status == ST_OK);
  assign out_date_sane   = (out_result_month >= 4'd1) && (out_result_month <= 4'd12) &&
                           (out_result_day != 5'd0) && (out_result_year != 14'd0);
  assign out_fields_zero = (out_result_year == 14'd0) && (out_result_month == 4'd0) &&
                           (out_result_day == 5'd0) && (out_weekday == 3'd0);

  `CHK_HOLDS(a_ok_date, out_ok |-> out_date_sane, "ok word carries an impossible date")
  `CHK_HOLDS(a_err_zero, (out_valid && !out_ok) |-> out_fields_zero, "error word has nonzero fields")
  `CHK_NEVER(a_wk_range, out_valid && out_weekday == 3'd7, "weekday out of range")

endmodule

@@ tb/sv/gdow_checker.sv @@
// Checker that predicts each result date, weekday and status and compares it with the block.
`timescale 1ns / 1ps

module gdow_checker
  import gdow_pkg::*;
#(
  parameter int OFFSET_WIDTH = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [13:0]                    in_start_year,
  input  logic [3:0]                     in_start_month,
  input  logic [4:0]                     in_start_day,
  input  logic signed [OFFSET_WIDTH-1:0] in_day_offset,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [13:0]                    out_result_year,
  input  logic [3:0]                     out_result_month,
  input  logic [4:0]                     out_result_day,
  input  logic [2:0]                     out_weekday,
  input  logic [1:0]                     out_status,
  output int                             fail_count,
  output int                             pending_dates
);

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    status_t     status;
  } date_word_t;

  date_word_t expected_dates[$];

  function automatic bit is_leap(int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int month_days(int y, int m);
    int n;
    n = (m >= 1 && m <= 12) ? int'(MONTH_LEN[m]) : 0;
    if (m == 2 && is_leap(y)) n++;
    return n;
  endfunction

  function automatic date_word_t shift_date(int y, int m, int d, longint off);
    date_word_t r;
    longint n;
    int p, rem, ry, rm, q;
    r = '0;
    r.status = ST_OK;
    if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
      r.status = ST_BAD_START;
      return r;
    end
    p = y - 1;
    n = longint'(p) * 365 + p / 4 - p / 100 + p / 400;
    for (int k = 1; k < m; k++) n += month_days(y, k);
    n = n + d - 1 + off;
    if (n < 0 || n > 3652058) begin
      r.status = ST_RANGE;
      return r;
    end
    rem = int'(n);
    ry = (rem / 146097) * 400;
    rem = rem % 146097;
    q = rem / 36524;
    if (q > 3) q = 3;
    ry += q * 100;
    rem -= q * 36524;
    ry += (rem / 1461) * 4;
    rem = rem % 1461;
    q = rem / 365;
    if (q > 3) q = 3;
    ry += q + 1;
    rem -= q * 365;
    rm = 1;
    while (rm < 12 && rem >= month_days(ry, rm)) begin
      rem -= month_days(ry, rm);
      rm++;
    end
    r.year = 14'(ry);
    r.month = 4'(rm);
    r.day = 5'(rem + 1);
    r.wday = 3'((n + 1) % 7);
    return r;
  endfunction

  assign pending_dates = expected_dates.size();

  always @(posedge clk) begin
    date_word_t exp_w;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_dates.push_back(shift_date(in_start_year, in_start_month, in_start_day,
                                            longint'(in_day_offset)));
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_dates.pop_front();
          if (out_status !== exp_w.status || out_result_year !== exp_w.year ||
              out_result_month !== exp_w.month || out_result_day !== exp_w.day ||
              out_weekday !== exp_w.wday) begin
            if (out_status !== exp_w.status)
              $error("status: expected %0d, actual %0d", exp_w.status, out_status);
            if (out_result_year !== exp_w.year)
              $error("result_year: expected %0d, actual %0d", exp_w.year, out_result_year);
            if (out_result_month !== exp_w.month)
              $error("result_month: expected %0d, actual %0d", exp_w.month, out_result_month);
            if (out_result_day !== exp_w.day)
              $error("result_day: expected %0d, actual %0d", exp_w.day, out_result_day);
            if (out_weekday !== exp_w.wday)
              $error("weekday: expected %0d, actual %0d", exp_w.wday, out_weekday);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_gregorian_date_offset_weekday.sv @@
// Testbench top: drives date words into the block and gives the verdict.
`timescale 1ns / 1ps

module tb_gregorian_date_offset_weekday;
  import gdow_pkg::*;

  localparam int OW = 17;
  localparam int RANDOM_DATES = 1500;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [13:0] in_start_year = '0;
  logic [3:0] in_start_month = '0;
  logic [4:0] in_start_day = '0;
  logic signed [OW-1:0] in_day_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [13:0] out_result_year;
  logic [3:0] out_result_month;
  logic [4:0] out_result_day;
  logic [2:0] out_weekday;
  logic [1:0] out_status;
  int fail_count;
  int pending_dates;
  int cycle_count = 0;
  bit idle_free = 1'b0;

  always #4 clk = ~clk;

  gregorian_date_offset_weekday #(.OFFSET_WIDTH(OW)) i_dut (.*);
  gdow_checker #(.OFFSET_WIDTH(OW)) i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gregorian_date_offset_weekday: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random, except for one long hold-off to fill the pipeline.
  initial begin
    repeat (10) @(posedge clk);
    repeat (300) @(posedge clk) out_stall <= !idle_free && ($urandom_range(99) < 8);
    out_stall <= 1'b1;
    repeat (200) @(posedge clk);
    forever @(posedge clk) out_stall <= !idle_free && ($urandom_range(99) < 8);
  end

  task automatic send_date(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                           logic signed [OW-1:0] off);
    while (!idle_free && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_year <= y;
    in_start_month <= m;
    in_start_day <= d;
    in_day_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int y, m, k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: field extremes, invalid starts, range errors, leap boundaries.
    send_date(14'd1, 4'd1, 5'd1, 17'sd0);
    send_date(14'd1, 4'd1, 5'd1, -17'sd1);
    send_date(14'd9999, 4'd12, 5'd31, 17'sd0);
    send_date(14'd9999, 4'd12, 5'd31, 17'sd1);
    send_date(14'd0, 4'd5, 5'd5, 17'sd3);
    send_date(14'd16383, 4'd15, 5'd31, -17'sd65536);
    send_date(14'd10000, 4'd1, 5'd1, 17'sd0);
    send_date(14'd2000, 4'd0, 5'd1, 17'sd0);
    send_date(14'd2000, 4'd13, 5'd1, 17'sd0);
    send_date(14'd2000, 4'd3, 5'd0, 17'sd0);
    send_date(14'd2000, 4'd2, 5'd29, 17'sd1);
    send_date(14'd1900, 4'd2, 5'd29, 17'sd0);
    send_date(14'd2100, 4'd2, 5'd28, 17'sd1);
    send_date(14'd2004, 4'd4, 5'd31, 17'sd0);
    send_date(14'd2024, 4'd12, 5'd31, 17'sd65535);
    send_date(14'd2024, 4'd1, 5'd1, -17'sd65536);
    send_date(14'd9900, 4'd1, 5'd1, 17'sd65535);
    send_date(14'd100, 4'd3, 5'd1, -17'sd65536);
    send_date(14'd0, 4'd0, 5'd0, 17'sd65535);
    send_date(14'd1600, 4'd2, 5'd29, 17'sd366);
    for (k = 0; k < RANDOM_DATES; k++) begin
      idle_free = (k >= 600 && k < 800);
      y = (k % 5 == 0) ? $urandom_range(16383) :
          (k % 5 == 1) ? $urandom_range(200, 1) : $urandom_range(9999, 1);
      if (k % 5 == 2) y = 9999 - $urandom_range(180);
      m = (k % 10 == 3) ? $urandom_range(15) : $urandom_range(12, 1);
      send_date(14'(y), 4'(m),
                (k % 10 == 4) ? 5'($urandom_range(31)) :
                                5'($urandom_range((m == 2) ? 29 : 31, 1)),
                (k % 3 == 0) ? OW'($urandom) : OW'(int'($urandom_range(800)) - 400));
    end
    idle_free = 1'b0;
    in_valid <= 1'b0;
    // Let the checker record the last accepted word before waiting for the drain.
    @(posedge clk);
    while (pending_dates != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("gregorian_date_offset_weekday: match");
    else
      $display("gregorian_date_offset_weekday: mismatch");
    $finish;
  end

endmodule
